FILE: design/mse_pkg.sv
// Shared constants for the merge sort engine.
`default_nettype none
package mse_pkg;
  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 64;
endpackage
`default_nettype wire

FILE: design/mse_ram.sv
// Element buffer bank: one write port and two registered read ports.
`default_nettype none
module mse_ram #(
  parameter int DEPTH = mse_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [mse_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]                     raddr_a,
  input  wire logic [AW-1:0]                     raddr_b,
  output logic signed [mse_pkg::DATA_W-1:0]      rdata_a,
  output logic signed [mse_pkg::DATA_W-1:0]      rdata_b
);
  import mse_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

FILE: design/mse_cmp.sv
// Merge step unit: picks the next element from the heads of the two runs.
`default_nettype none
module mse_cmp (
  input  wire logic signed [mse_pkg::DATA_W-1:0] left_val,
  input  wire logic signed [mse_pkg::DATA_W-1:0] right_val,
  input  wire logic                              left_ok,
  input  wire logic                              right_ok,
  output logic                                   take_left,
  output logic signed [mse_pkg::DATA_W-1:0]      sel_val
);
  import mse_pkg::*;

  // Equal values take the left run, which keeps the merge stable.
  always_comb begin
    take_left = left_ok && (!right_ok || (left_val <= right_val));
    sel_val   = take_left ? left_val : right_val;
  end
endmodule
`default_nettype wire

FILE: design/merge_sort_engine_core.sv
// Top level of the merge sort engine: load, bottom-up merge and emit sequencer.
`default_nettype none
// A transaction is taken when start is high and busy is low; each one carries a
// signed 32-bit sample and a set_end flag. Loading takes one transaction per
// cycle and busy stays low while a set is being collected. A set closes on
// set_end, or on the DEPTH-th sample, in which case every result of that set
// carries set_truncated unless set_end came with it. Busy then rises and the
// set of n values is sorted by bottom-up merging between two buffer banks: each
// pass handles each element with a registered read, then a compare and write,
// with a setup step for every pair of runs, and there are ceil(log2 n) passes.
// The sorted values then leave one by one, each shown for exactly one cycle
// with result_valid high, the last one flagged by final_element. The receiver
// cannot stall the output. The sort uses the single shared compare unit and
// the registered read of the buffer banks. Busy falls in the cycle that shows
// the final result, so the next set may start at once.
module merge_sort_engine_core #(
  parameter int DEPTH = mse_pkg::DEFAULT_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [mse_pkg::DATA_W-1:0] sample_value,
  input  wire logic                              set_end,
  output logic                                   result_valid,
  output logic signed [mse_pkg::DATA_W-1:0]      sorted_value,
  output logic                                   final_element,
  output logic                                   set_truncated
);
  import mse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  // Counts and run bounds must hold DEPTH itself.
  localparam int NW = $clog2(DEPTH + 1);
  // Intermediate run bounds can reach about three times DEPTH before clamping.
  localparam int SW = NW + 2;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_SETUP   = 6'b000010,
    S_RD      = 6'b000100,
    S_CMP     = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_WR = 6'b100000
  } state_t;

  state_t        state;
  logic [NW-1:0] count;      // samples loaded into the current set
  logic [NW-1:0] n;          // size of the set being sorted
  logic          truncated;  // set was cut at DEPTH samples
  logic          src;        // bank that holds the current runs
  logic [NW-1:0] w;          // run width of the current pass
  logic [NW-1:0] lo;         // start of the current pair of runs
  logic [NW-1:0] mid;        // end of the left run
  logic [NW-1:0] hi;         // end of the right run
  logic [NW-1:0] i;          // head of the left run
  logic [NW-1:0] j;          // head of the right run
  logic [NW-1:0] k;          // write position, also the emit position

  logic [NW-1:0] cnt_inc;
  logic [NW-1:0] k_inc;
  logic          last_item;
  logic [NW:0]   w2;
  logic [SW-1:0] mid_sum;
  logic [SW-1:0] hi_sum;
  logic [SW-1:0] lo_step;
  logic          emit_phase;

  logic          we0;
  logic          we1;
  logic [AW-1:0] waddr0;
  logic [AW-1:0] waddr1;
  logic signed [DATA_W-1:0] wdata0;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic signed [DATA_W-1:0] rd0_a;
  logic signed [DATA_W-1:0] rd0_b;
  logic signed [DATA_W-1:0] rd1_a;
  logic signed [DATA_W-1:0] rd1_b;
  logic signed [DATA_W-1:0] left_val;
  logic signed [DATA_W-1:0] right_val;
  logic signed [DATA_W-1:0] sel_val;
  logic          take_left;

  assign busy = (state != S_LOAD);

  always_comb begin
    cnt_inc    = count + NW'(1);
    k_inc      = k + NW'(1);
    last_item  = set_end || (cnt_inc == NW'(DEPTH));
    w2         = {w, 1'b0};
    mid_sum    = SW'(lo) + SW'(w);
    hi_sum     = SW'(lo) + SW'(w2);
    lo_step    = hi_sum;
    emit_phase = (state == S_EMIT_RD) || (state == S_EMIT_WR);
  end

  // Both banks see the same read addresses; the source bank is picked after
  // the registered read. During the emit phase port A walks the output order.
  always_comb begin
    raddr_a   = emit_phase ? k[AW-1:0] : i[AW-1:0];
    raddr_b   = j[AW-1:0];
    left_val  = src ? rd1_a : rd0_a;
    right_val = src ? rd1_b : rd0_b;
  end

  // Bank 0 takes the loaded samples and the merge output of even passes;
  // bank 1 takes the merge output of odd passes, the first pass included.
  always_comb begin
    we0    = ((state == S_LOAD) && start) || ((state == S_CMP) && src);
    waddr0 = (state == S_LOAD) ? count[AW-1:0] : k[AW-1:0];
    wdata0 = (state == S_LOAD) ? sample_value : sel_val;
    we1    = (state == S_CMP) && !src;
    waddr1 = k[AW-1:0];
  end

  mse_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mse_ram #(.DEPTH(DEPTH), .AW(AW)) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr1),
    .wdata   (sel_val),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  mse_cmp u_cmp (
    .left_val  (left_val),
    .right_val (right_val),
    .left_ok   (i < mid),
    .right_ok  (j < hi),
    .take_left (take_left),
    .sel_val   (sel_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      src          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (start) begin
            count <= cnt_inc;
            if (last_item) begin
              // The set is closed; the next transaction opens a new one.
              n         <= cnt_inc;
              truncated <= !set_end;
              count     <= '0;
              src       <= 1'b0;
              w         <= NW'(1);
              lo        <= '0;
              k         <= '0;
              state     <= (cnt_inc == NW'(1)) ? S_EMIT_RD : S_SETUP;
            end
          end
        end
        S_SETUP: begin
          // Bounds of the next pair of runs, clamped to the set size.
          mid   <= (mid_sum > SW'(n)) ? n : mid_sum[NW-1:0];
          hi    <= (hi_sum > SW'(n)) ? n : hi_sum[NW-1:0];
          i     <= lo;
          j     <= (mid_sum > SW'(n)) ? n : mid_sum[NW-1:0];
          k     <= lo;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (take_left) begin
            i <= i + NW'(1);
          end else begin
            j <= j + NW'(1);
          end
          k     <= k_inc;
          state <= S_RD;
          if (k_inc == hi) begin
            if (lo_step >= SW'(n)) begin
              // Pass complete: the merged runs now live in the other bank.
              src <= !src;
              w   <= w2[NW-1:0];
              if (w2 >= {1'b0, n}) begin
                k     <= '0;
                state <= S_EMIT_RD;
              end else begin
                lo    <= '0;
                state <= S_SETUP;
              end
            end else begin
              lo    <= lo_step[NW-1:0];
              state <= S_SETUP;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          sorted_value  <= left_val;
          final_element <= (k_inc == n);
          set_truncated <= truncated;
          result_valid  <= 1'b1;
          if (k_inc == n) begin
            state <= S_LOAD;
          end else begin
            k     <= k_inc;
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/merge_sort_engine_core_checker.sv
// Port-level checks for the merge sort engine, bound to the top level.
`default_nettype none
module merge_sort_engine_core_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic set_end,
  input wire logic result_valid,
  input wire logic final_element
);
  // A transaction that closes the set starts the sort.
  a_end_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && set_end) |=> busy)
    else $error("set end did not raise busy");

  // Busy only rises after an accepted transaction.
  a_busy_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transaction");

  // Outside the final result the engine is still busy emitting.
  a_valid_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (busy || final_element))
    else $error("result shown while idle");

  // The final result of a set is never directly followed by another result.
  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && final_element) |=> !result_valid)
    else $error("result right after final element");
endmodule

bind merge_sort_engine_core merge_sort_engine_core_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .set_end       (set_end),
  .result_valid  (result_valid),
  .final_element (final_element)
);
`default_nettype wire

FILE: tb/merge_sort_engine_core_tb.sv
// Self-checking testbench for the merge sort engine core.
`default_nettype none
module merge_sort_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  // The engine is built at its default depth. A set closes on set_end or
  // when it reaches this many samples.
  localparam int SET_DEPTH = DEFAULT_DEPTH;

  // Target for the total number of sample transactions in the run.
  localparam int ITEM_TARGET = 270;

  // One sorted value as the engine should present it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     cut;
  } sorted_entry_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic signed [DATA_W-1:0] sample_value = '0;
  logic                     set_end = 1'b0;
  logic                     busy;
  logic                     result_valid;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_element;
  logic                     set_truncated;

  // Samples of the set now being loaded, kept in ascending order. A new value
  // goes after every value that is less than or equal to it, so equal values
  // keep their arrival order, which is what a stable merge gives.
  logic signed [DATA_W-1:0] open_set[$];

  // Sorted values still owed by the engine, oldest first.
  sorted_entry_t            sorted_due[$];

  int mismatch_count = 0;
  int samples_sent   = 0;
  int sets_closed    = 0;
  int sets_cut       = 0;
  int results_seen   = 0;
  int largest_set    = 0;

  // When set, the sender leaves no idle cycles between transactions.
  bit back_to_back = 1'b0;

  merge_sort_engine_core #(
    .DEPTH(SET_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .set_end      (set_end),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .final_element(final_element),
    .set_truncated(set_truncated)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the engine hangs. The slowest legal run is far shorter:
  // there are only a few hundred transactions, and each set sort and each gap
  // between transactions is short.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Prints one line per mismatch and keeps the count for the final verdict.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Adds an accepted sample to the open set. When the sample closes the set,
  // either by its end flag or by filling the buffer, the whole set in sorted
  // order becomes the list of values the engine owes.
  task automatic load_sample(input logic signed [DATA_W-1:0] value, input logic closes);
    int pos;
    int n;
    sorted_entry_t entry;
    for (pos = 0; pos < open_set.size(); pos++) begin
      if (open_set[pos] > value) break;
    end
    open_set.insert(pos, value);
    if (closes || open_set.size() == SET_DEPTH) begin
      n = open_set.size();
      for (int k = 0; k < n; k++) begin
        entry.value = open_set[k];
        entry.last  = (k == n - 1);
        entry.cut   = !closes;
        sorted_due.insert(sorted_due.size(), entry);
      end
      sets_closed++;
      if (!closes) sets_cut++;
      if (n > largest_set) largest_set = n;
      open_set.delete();
    end
  endtask

  // Mostly short gaps, sometimes none, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (back_to_back || roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values lean on the extremes and on a narrow band, so that ties and
  // sign boundaries come up often; the rest are fully random.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2, 3:    return DATA_W'(int'($urandom_range(0, 6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  // Offers one sample transaction and holds it until the engine takes it.
  // With no gap after it, start simply stays high for the next one.
  task automatic send_sample(input logic signed [DATA_W-1:0] value, input logic closes);
    int gap;
    start        <= 1'b1;
    sample_value <= value;
    set_end      <= closes;
    @(posedge clk);
    while (busy) @(posedge clk);
    samples_sent++;
    load_sample(value, closes);
    gap = pick_gap();
    if (gap > 0) begin
      start        <= 1'b0;
      sample_value <= $urandom();
      set_end      <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a set of random values. With flag_last clear and n equal to the
  // buffer depth, the engine has to cut the set itself.
  task automatic send_set(input int n, input bit flag_last);
    for (int k = 0; k < n; k++) begin
      send_sample(pick_value(), flag_last && (k == n - 1));
    end
  endtask

  // Every result the engine shows is taken at the edge that ends its cycle
  // and compared with the oldest value still owed.
  always @(posedge clk) begin : result_checker
    sorted_entry_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        report_mismatch("unexpected result, value", sorted_value, '0);
      end else begin
        want = sorted_due.pop_front();
        if (sorted_value !== want.value)
          report_mismatch("sorted_value", sorted_value, want.value);
        if (final_element !== want.last)
          report_mismatch("final_element", DATA_W'(final_element), DATA_W'(want.last));
        if (set_truncated !== want.cut)
          report_mismatch("set_truncated", DATA_W'(set_truncated), DATA_W'(want.cut));
      end
    end
  end

  // A set of one element, at each extreme and at zero.
  task automatic test_single_element();
    send_sample({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    send_sample({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
    send_sample('0, 1'b1);
  endtask

  // Extremes in reverse order, then a set that straddles zero.
  task automatic test_extremes();
    send_sample({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(0, 1'b0);
    send_sample({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
  endtask

  // Repeated values across runs of every width.
  task automatic test_ties();
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(5, 1'b1);
  endtask

  // End flag on the last slot of the buffer: a normal close, not a cut.
  task automatic test_full_set_flagged();
    send_set(SET_DEPTH, 1'b1);
  endtask

  // No end flag: the buffer fills and the engine cuts the set. A short set
  // right after shows that the sample count was cleared.
  task automatic test_full_set_cut();
    send_set(SET_DEPTH, 1'b0);
    send_set(3, 1'b1);
  endtask

  // Random sets, mostly small, some medium, a few full ones, some of them
  // sent back to back so gaps and no gaps both fall on every phase.
  task automatic test_random_sets();
    int roll;
    int n;
    while (samples_sent < ITEM_TARGET) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        n = $urandom_range(1, 12);
        send_set(n, 1'b1);
      end else if (roll < 94) begin
        n = $urandom_range(13, SET_DEPTH - 1);
        send_set(n, 1'b1);
      end else begin
        send_set(SET_DEPTH, 1'($urandom_range(0, 1)));
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin : run_tests
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_element();
    test_extremes();
    test_ties();
    test_full_set_flagged();
    test_full_set_cut();
    test_random_sets();
    start <= 1'b0;

    // Drain what is still owed, then give the engine time to show anything
    // extra it should not have produced.
    waited = 0;
    while (sorted_due.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sorted_due.size() != 0)
      report_mismatch("results never shown, count", DATA_W'(sorted_due.size()), '0);

    $display("Sent %0d sample transactions in %0d sets (%0d cut at full depth).",
             samples_sent, sets_closed, sets_cut);
    $display("Checked %0d sorted results; largest set held %0d values.",
             results_seen, largest_set);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
